// ===== sv/cfe_pkg.sv =====
`default_nettype none

package cfe_pkg;

	// run store geometry and fixed code bytes
	localparam int unsigned RunDepth = 254;
	localparam logic [7:0] RunFull = 8'(RunDepth);
	localparam logic [7:0] FullCode = 8'hFF;
	localparam logic [7:0] EmptyCode = 8'h01;
	localparam int unsigned LaneCount = 4;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic flush_req;
		logic last_byte;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/cfe_ctrl.sv =====
`default_nettype none

module cfe_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire cfe_pkg::sts_t sts,
	output cfe_pkg::cmd_t     cmd
);
	import cfe_pkg::*;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.flush_req) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.last_byte) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// commands
	assign in_stall = (state_q != ST_IDLE);
	assign cmd.take = (state_q == ST_IDLE) && in_valid;
	assign cmd.emit = (state_q == ST_EMIT);

endmodule

`default_nettype wire

// ===== sv/cfe_datapath.sv =====
`default_nettype none

module cfe_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfe_pkg::cmd_t cmd,
	output cfe_pkg::sts_t      sts,
	input  wire logic [7:0]    data_byte,
	input  wire logic          byte_valid,
	input  wire logic          frame_end,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte_0,
	output logic [7:0]         out_byte_1,
	output logic [7:0]         out_byte_2,
	output logic [7:0]         out_byte_3,
	output logic [2:0]         byte_count,
	output logic               run_last,
	output logic               frame_last
);
	import cfe_pkg::*;

	// run store
	logic [7:0] mem_q [RunDepth];
	logic [7:0] rd_q;

	logic [7:0] len_q;
	logic [7:0] code_q;
	logic [7:0] n_q;
	logic       end_q;
	logic [8:0] cnt_q;
	logic [8:0] last_q;

	// pack buffer
	logic [7:0] pbyte_q [LaneCount];
	logic [2:0] pcnt_q;
	logic       pfull_q;
	logic       prun_q;
	logic       plast_q;

	// output register
	logic       ov_q;
	logic [7:0] obyte_q [LaneCount];
	logic [2:0] ocnt_q;
	logic       orun_q;
	logic       olast_q;

	logic [7:0] new_len;
	logic       is_zero;
	logic       full;
	logic       store_wr;
	logic       xfer;
	logic       adv;
	logic       last;
	logic [1:0] slot;
	logic [7:0] cur_byte;

	// input decode
	assign new_len  = len_q + 8'd1;
	assign is_zero  = (data_byte == 8'd0);
	assign full     = (new_len == RunFull);
	assign store_wr = cmd.take && byte_valid && !is_zero;
	assign sts.flush_req = byte_valid ? (is_zero || full || frame_end) : frame_end;

	// emission stepping
	assign xfer = pfull_q && (!ov_q || !out_stall);
	assign adv  = cmd.emit && (!pfull_q || xfer);
	assign last = (cnt_q == last_q);
	assign sts.last_byte = adv && last;
	assign slot = pfull_q ? 2'd0 : pcnt_q[1:0];

	always_comb begin
		if (cnt_q == 9'd0) cur_byte = code_q;
		else if (cnt_q <= {1'b0, n_q}) cur_byte = rd_q;
		else cur_byte = EmptyCode;
	end

	// store write and prefetch read
	always_ff @(posedge clk) begin
		if (store_wr) mem_q[len_q] <= data_byte;
		if (adv && (cnt_q < 9'(RunDepth))) rd_q <= mem_q[cnt_q[7:0]];
	end

	// run bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 8'd0;
			cnt_q <= 9'd0;
		end else begin
			if (cmd.take) begin
				cnt_q <= 9'd0;
				if (sts.flush_req) len_q <= 8'd0;
				else if (store_wr) len_q <= new_len;
			end else if (adv) begin
				cnt_q <= cnt_q + 9'd1;
			end
		end
	end

	// flush descriptor
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			end_q <= frame_end;
			if (byte_valid && is_zero) begin
				code_q <= new_len;
				n_q    <= len_q;
				last_q <= {1'b0, len_q} + {8'd0, frame_end};
			end else if (byte_valid && full) begin
				code_q <= FullCode;
				n_q    <= new_len;
				last_q <= {1'b0, new_len} + {8'd0, frame_end};
			end else if (byte_valid) begin
				code_q <= new_len + 8'd1;
				n_q    <= new_len;
				last_q <= {1'b0, new_len};
			end else begin
				code_q <= new_len;
				n_q    <= len_q;
				last_q <= {1'b0, len_q};
			end
		end
	end

	// pack buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pfull_q <= 1'b0;
			pcnt_q  <= 3'd0;
		end else if (adv) begin
			pcnt_q  <= {1'b0, slot} + 3'd1;
			pfull_q <= (slot == 2'd3) || last;
		end else if (xfer) begin
			pcnt_q  <= 3'd0;
			pfull_q <= 1'b0;
		end
	end

	// pack buffer bytes, unused lanes cleared on a fresh result
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LaneCount; i++) begin
				if (i == int'(slot)) pbyte_q[i] <= cur_byte;
				else if (slot == 2'd0) pbyte_q[i] <= 8'd0;
			end
			prun_q  <= last;
			plast_q <= last && end_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (xfer) ov_q <= 1'b1;
		else if (!out_stall) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			for (int i = 0; i < LaneCount; i++) obyte_q[i] <= pbyte_q[i];
			ocnt_q  <= pcnt_q;
			orun_q  <= prun_q;
			olast_q <= plast_q;
		end
	end

	assign out_valid  = ov_q;
	assign out_byte_0 = obyte_q[0];
	assign out_byte_1 = obyte_q[1];
	assign out_byte_2 = obyte_q[2];
	assign out_byte_3 = obyte_q[3];
	assign byte_count = ocnt_q;
	assign run_last   = orun_q;
	assign frame_last = olast_q;

endmodule

`default_nettype wire

// ===== sv/cobs_frame_encoder.sv =====
`default_nettype none

// COBS frame encoder without trailing delimiter. Feed one raw byte per request
// (byte_valid), mark the last request of a frame with frame_end; an end-only
// request closes the frame as well. Nonzero bytes collect in a 254-entry run
// store; a zero byte, a full run or the frame end flushes the run as a code
// byte plus the stored bytes, packed up to four per result. A request that
// flushes nothing is taken without holding the input. A flushing request
// holds the input while the code byte, the n stored bytes and any trailing
// 0x01 are sent, since the bytes leave the run store through its single read
// port one per cycle unless the output stalls. Results pass through an output
// register, so the next request is taken while the last result still waits.
module cobs_frame_encoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       byte_valid,
	input  wire logic       frame_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte_0,
	output logic [7:0]      out_byte_1,
	output logic [7:0]      out_byte_2,
	output logic [7:0]      out_byte_3,
	output logic [2:0]      byte_count,
	output logic            run_last,
	output logic            frame_last
);
	import cfe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	cfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// run store, packing and output register
	cfe_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.data_byte  (data_byte),
		.byte_valid (byte_valid),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte_0 (out_byte_0),
		.out_byte_1 (out_byte_1),
		.out_byte_2 (out_byte_2),
		.out_byte_3 (out_byte_3),
		.byte_count (byte_count),
		.run_last   (run_last),
		.frame_last (frame_last)
	);

endmodule

`default_nettype wire
